>>> rtl/core/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// Holds payload widths, item and status codes, and the controller-to-datapath
// command and status structs. No dependencies.
package spq_pkg;

  // Payload widths, fixed by the item format.
  localparam int DATA_W    = 32;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int OUT_CNT_W = 5;

  // Item kinds. Any kind that is neither enqueue nor dequeue only inspects.
  localparam logic [KIND_W-1:0] KIND_ENQ = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEQ = 2'd1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Index register operations.
  localparam logic [2:0] IDX_HOLD = 3'd0;
  localparam logic [2:0] IDX_ZERO = 3'd1;
  localparam logic [2:0] IDX_LAST = 3'd2;
  localparam logic [2:0] IDX_INC  = 3'd3;
  localparam logic [2:0] IDX_DEC  = 3'd4;

  // Write address selection: zero, or relative to the index of the entry just read.
  localparam logic [1:0] WA_ZERO = 2'd0;
  localparam logic [1:0] WA_UP   = 2'd1;
  localparam logic [1:0] WA_DOWN = 2'd2;

  // Entry counter operations.
  localparam logic [1:0] CNT_HOLD = 2'd0;
  localparam logic [1:0] CNT_INC  = 2'd1;
  localparam logic [1:0] CNT_DEC  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;        // capture the accepted item, clear the working result
    logic [2:0] idx_op;      // next read index
    logic       wr_en;       // write the entry store
    logic [1:0] wr_addr_sel; // where the write goes
    logic       wr_new;      // write the new pair rather than the entry just read
    logic [1:0] cnt_op;      // entry counter update
    logic       take_front;  // capture the entry just read as the removed pair
    logic       scan_acc;    // fold the entry just read into front, rear, max, min
    logic       publish;     // move the working result to the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_enq;     // held item is an enqueue
    logic is_deq;     // held item is a dequeue
    logic cnt_zero;   // store is empty
    logic cnt_one;    // store holds exactly one entry
    logic cnt_full;   // store is full
    logic pri_ge;     // entry just read has priority equal or higher than the new one
    logic pidx_zero;  // entry just read is the front
    logic pidx_last;  // entry just read is the last stored
    logic out_busy;   // output register holds a result that is not taken this cycle
  } dp_sts_t;

endpackage

>>> rtl/core/spq_in_if.sv
// Input channel of the sorted priority queue: valid, ready and one item.
// Depends on spq_pkg for the payload widths.
interface spq_in_if import spq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] value;
  logic signed [DATA_W-1:0] priority_req;

  modport source (output valid, output kind, output value, output priority_req,
                  input ready);
  modport sink   (input valid, input kind, input value, input priority_req,
                  output ready);
endinterface

>>> rtl/core/spq_out_if.sv
// Result channel of the sorted priority queue: valid, ready and one result item.
// Depends on spq_pkg for the payload widths.
interface spq_out_if import spq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] front_priority;
  logic signed [DATA_W-1:0] rear_value;
  logic signed [DATA_W-1:0] rear_priority;
  logic [OUT_CNT_W-1:0]     entry_count;
  logic signed [DATA_W-1:0] largest_value;
  logic signed [DATA_W-1:0] smallest_value;

  modport source (output valid, output status, output front_value,
                  output front_priority, output rear_value, output rear_priority,
                  output entry_count, output largest_value, output smallest_value,
                  input ready);
  modport sink   (input valid, input status, input front_value,
                  input front_priority, input rear_value, input rear_priority,
                  input entry_count, input largest_value, input smallest_value,
                  output ready);
endinterface

>>> rtl/core/spq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; contents are undefined until written.
module spq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/core/spq_dp.sv
// Datapath of the sorted priority queue: entry store, index and count
// registers, working result and output register. Depends on spq_pkg and spq_ram.
module spq_dp import spq_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_cmd_t                  cmd,
  output dp_sts_t                  sts,
  input  logic [KIND_W-1:0]        in_kind,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic signed [DATA_W-1:0] in_priority,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic [STATUS_W-1:0]      out_status,
  output logic signed [DATA_W-1:0] out_front_value,
  output logic signed [DATA_W-1:0] out_front_priority,
  output logic signed [DATA_W-1:0] out_rear_value,
  output logic signed [DATA_W-1:0] out_rear_priority,
  output logic [OUT_CNT_W-1:0]     out_entry_count,
  output logic signed [DATA_W-1:0] out_largest_value,
  output logic signed [DATA_W-1:0] out_smallest_value
);

  localparam int ADDR_W  = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int ENTRY_W = 2 * DATA_W;

  // Control registers.
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Index registers: idx_r addresses the read, pidx_r names the entry on rd_q.
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [ADDR_W-1:0] pidx_r;

  // Held item.
  logic [KIND_W-1:0]        kind_r;
  logic signed [DATA_W-1:0] value_r;
  logic signed [DATA_W-1:0] pri_r;

  // Working result.
  logic [STATUS_W-1:0]      status_r;
  logic                     front_taken_r;
  logic signed [DATA_W-1:0] fv_r, fp_r, rv_r, rp_r, mx_r, mn_r;

  // Output register.
  logic [STATUS_W-1:0]      o_status_r;
  logic signed [DATA_W-1:0] o_fv_r, o_fp_r, o_rv_r, o_rp_r, o_mx_r, o_mn_r;
  logic [OUT_CNT_W-1:0]     o_cnt_r;

  // Store interface.
  logic [ADDR_W-1:0]        wr_addr;
  logic [ENTRY_W-1:0]       wr_data;
  logic [ENTRY_W-1:0]       rd_q;
  logic signed [DATA_W-1:0] rd_val;
  logic signed [DATA_W-1:0] rd_pri;

  logic [CNT_W-1:0]           cnt_m1;
  logic [CNT_W+OUT_CNT_W-1:0] cnt_ext;
  logic                       cnt_full;
  logic                       cnt_zero;

  spq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (idx_r),
    .rd_data (rd_q)
  );

  assign rd_val   = $signed(rd_q[ENTRY_W-1:DATA_W]);
  assign rd_pri   = $signed(rd_q[DATA_W-1:0]);
  assign cnt_m1   = count_r - CNT_W'(1);
  assign cnt_full = (count_r == CNT_W'(CAPACITY));
  assign cnt_zero = (count_r == '0);
  assign cnt_ext  = {{OUT_CNT_W{1'b0}}, count_r};

  // Write address and data for shifting and insertion.
  always_comb begin
    unique case (cmd.wr_addr_sel)
      WA_UP:   wr_addr = pidx_r + ADDR_W'(1);
      WA_DOWN: wr_addr = pidx_r - ADDR_W'(1);
      default: wr_addr = '0;
    endcase
    wr_data = cmd.wr_new ? {value_r, pri_r} : rd_q;
  end

  // Next read index.
  always_comb begin
    unique case (cmd.idx_op)
      IDX_ZERO: idx_nxt = '0;
      IDX_LAST: idx_nxt = cnt_m1[ADDR_W-1:0];
      IDX_INC:  idx_nxt = idx_r + ADDR_W'(1);
      IDX_DEC:  idx_nxt = idx_r - ADDR_W'(1);
      default:  idx_nxt = idx_r;
    endcase
  end

  // Entry count and output handshake.
  always_comb begin
    unique case (cmd.cnt_op)
      CNT_INC: count_nxt = count_r + CNT_W'(1);
      CNT_DEC: count_nxt = cnt_m1;
      default: count_nxt = count_r;
    endcase
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Index registers.
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    pidx_r <= idx_r;
  end

  // Held item and working result.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r        <= in_kind;
      value_r       <= in_value;
      pri_r         <= in_priority;
      front_taken_r <= 1'b0;
      fv_r          <= '0;
      fp_r          <= '0;
      rv_r          <= '0;
      rp_r          <= '0;
      mx_r          <= '0;
      mn_r          <= '0;
      if (in_kind == KIND_ENQ && cnt_full) begin
        status_r <= ST_FULL;
      end else if (in_kind != KIND_ENQ && cnt_zero) begin
        status_r <= ST_EMPTY;
      end else begin
        status_r <= ST_OK;
      end
    end else begin
      if (cmd.take_front) begin
        fv_r          <= rd_val;
        fp_r          <= rd_pri;
        front_taken_r <= 1'b1;
      end
      if (cmd.scan_acc) begin
        if (pidx_r == '0) begin
          mx_r <= rd_val;
          mn_r <= rd_val;
          if (!front_taken_r) begin
            fv_r <= rd_val;
            fp_r <= rd_pri;
          end
        end else begin
          if (rd_val > mx_r) begin
            mx_r <= rd_val;
          end
          if (rd_val < mn_r) begin
            mn_r <= rd_val;
          end
        end
        if (sts.pidx_last) begin
          rv_r <= rd_val;
          rp_r <= rd_pri;
        end
      end
    end
  end

  // Output register, loaded when the result is complete.
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      o_status_r <= status_r;
      o_fv_r     <= fv_r;
      o_fp_r     <= fp_r;
      o_rv_r     <= rv_r;
      o_rp_r     <= rp_r;
      o_mx_r     <= mx_r;
      o_mn_r     <= mn_r;
      o_cnt_r    <= cnt_ext[OUT_CNT_W-1:0];
    end
  end

  // Status towards the controller.
  always_comb begin
    sts.is_enq    = (kind_r == KIND_ENQ);
    sts.is_deq    = (kind_r == KIND_DEQ);
    sts.cnt_zero  = cnt_zero;
    sts.cnt_one   = (count_r == CNT_W'(1));
    sts.cnt_full  = cnt_full;
    sts.pri_ge    = !(rd_pri < pri_r);
    sts.pidx_zero = (pidx_r == '0);
    sts.pidx_last = (CNT_W'(pidx_r) == cnt_m1);
    sts.out_busy  = out_valid_r && !out_ready;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = o_status_r;
  assign out_front_value    = o_fv_r;
  assign out_front_priority = o_fp_r;
  assign out_rear_value     = o_rv_r;
  assign out_rear_priority  = o_rp_r;
  assign out_entry_count    = o_cnt_r;
  assign out_largest_value  = o_mx_r;
  assign out_smallest_value = o_mn_r;

endmodule

>>> rtl/core/spq_ctrl.sv
// Controller of the sorted priority queue: sequences insertion, removal and
// the closing scan of the store. Depends on spq_pkg.
module spq_ctrl import spq_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_DISPATCH   = 4'd1;
  localparam logic [3:0] S_ENQ_WAIT   = 4'd2;
  localparam logic [3:0] S_ENQ_CMP    = 4'd3;
  localparam logic [3:0] S_ENQ_FRONT  = 4'd4;
  localparam logic [3:0] S_DEQ_WAIT   = 4'd5;
  localparam logic [3:0] S_DEQ_TAKE   = 4'd6;
  localparam logic [3:0] S_DEQ_SHIFT  = 4'd7;
  localparam logic [3:0] S_SCAN_START = 4'd8;
  localparam logic [3:0] S_SCAN_WAIT  = 4'd9;
  localparam logic [3:0] S_SCAN_RUN   = 4'd10;
  localparam logic [3:0] S_DONE       = 4'd11;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt       = state_r;
    in_ready        = 1'b0;
    cmd.load        = 1'b0;
    cmd.idx_op      = IDX_HOLD;
    cmd.wr_en       = 1'b0;
    cmd.wr_addr_sel = WA_ZERO;
    cmd.wr_new      = 1'b0;
    cmd.cnt_op      = CNT_HOLD;
    cmd.take_front  = 1'b0;
    cmd.scan_acc    = 1'b0;
    cmd.publish     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        if (sts.is_enq && !sts.cnt_full) begin
          if (sts.cnt_zero) begin
            // Empty store: the new pair goes straight to the front.
            cmd.wr_en       = 1'b1;
            cmd.wr_addr_sel = WA_ZERO;
            cmd.wr_new      = 1'b1;
            cmd.cnt_op      = CNT_INC;
            state_nxt       = S_SCAN_START;
          end else begin
            cmd.idx_op = IDX_LAST;
            state_nxt  = S_ENQ_WAIT;
          end
        end else if (sts.is_deq && !sts.cnt_zero) begin
          cmd.idx_op = IDX_ZERO;
          state_nxt  = S_DEQ_WAIT;
        end else begin
          state_nxt = S_SCAN_START;
        end
      end

      // Insertion walks from the rear, moving each lower-priority entry
      // up one place, until an entry of equal or higher priority is seen.
      S_ENQ_WAIT: begin
        cmd.idx_op = IDX_DEC;
        state_nxt  = S_ENQ_CMP;
      end

      S_ENQ_CMP: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = WA_UP;
        if (sts.pri_ge) begin
          cmd.wr_new = 1'b1;
          cmd.cnt_op = CNT_INC;
          state_nxt  = S_SCAN_START;
        end else if (sts.pidx_zero) begin
          state_nxt = S_ENQ_FRONT;
        end else begin
          cmd.idx_op = IDX_DEC;
        end
      end

      S_ENQ_FRONT: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = WA_ZERO;
        cmd.wr_new      = 1'b1;
        cmd.cnt_op      = CNT_INC;
        state_nxt       = S_SCAN_START;
      end

      // Removal captures the front, then moves every other entry down one place.
      S_DEQ_WAIT: begin
        cmd.idx_op = IDX_INC;
        state_nxt  = S_DEQ_TAKE;
      end

      S_DEQ_TAKE: begin
        cmd.take_front = 1'b1;
        if (sts.cnt_one) begin
          cmd.cnt_op = CNT_DEC;
          state_nxt  = S_SCAN_START;
        end else begin
          cmd.idx_op = IDX_INC;
          state_nxt  = S_DEQ_SHIFT;
        end
      end

      S_DEQ_SHIFT: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_addr_sel = WA_DOWN;
        if (sts.pidx_last) begin
          cmd.cnt_op = CNT_DEC;
          state_nxt  = S_SCAN_START;
        end else begin
          cmd.idx_op = IDX_INC;
        end
      end

      // Closing scan gathers rear, largest and smallest value, and the front unless a dequeue took it.
      S_SCAN_START: begin
        if (sts.cnt_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd.idx_op = IDX_ZERO;
          state_nxt  = S_SCAN_WAIT;
        end
      end

      S_SCAN_WAIT: begin
        cmd.idx_op = IDX_INC;
        state_nxt  = S_SCAN_RUN;
      end

      S_SCAN_RUN: begin
        cmd.scan_acc = 1'b1;
        if (sts.pidx_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.idx_op = IDX_INC;
        end
      end

      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/sorted_priority_queue_unit.sv
// Sorted priority queue, one item at a time. An inspect is answered after a scan
// of the stored entries, skipped on an empty store; an enqueue into a non-empty,
// non-full store first walks from the rear to insert, a dequeue first moves the
// entries down. Each walk over the entry store reads one entry a cycle. The next
// item can be accepted once the result is registered, while it waits to be taken.
// Synchronous active-low reset empties the queue; stored data needs no clearing.
module sorted_priority_queue_unit import spq_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input logic       clk,
  input logic       rst_n,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  spq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_kind            (in_ch.kind),
    .in_value           (in_ch.value),
    .in_priority        (in_ch.priority_req),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_status         (out_ch.status),
    .out_front_value    (out_ch.front_value),
    .out_front_priority (out_ch.front_priority),
    .out_rear_value     (out_ch.rear_value),
    .out_rear_priority  (out_ch.rear_priority),
    .out_entry_count    (out_ch.entry_count),
    .out_largest_value  (out_ch.largest_value),
    .out_smallest_value (out_ch.smallest_value)
  );

  // An accepted item is worked on alone: no second item the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second item accepted while one is in progress");

  // A new result is published only from a state in which no item can enter.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(!in_ch.ready))
    else $error("result published while the input side was open");

  // An empty status leaves an empty store with rear, largest and smallest value zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_EMPTY) |->
      (out_ch.entry_count == '0 && out_ch.rear_value == '0 &&
       out_ch.largest_value == '0 && out_ch.smallest_value == '0))
    else $error("empty status with a non-empty report");

  // A dropped enqueue reports a full store.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_FULL) |->
      (out_ch.entry_count == OUT_CNT_W'(CAPACITY)))
    else $error("full status without a full store");

  // The largest stored value never falls below the smallest.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.entry_count != '0) |->
      (out_ch.largest_value >= out_ch.smallest_value))
    else $error("largest value below smallest value");

endmodule
